// ===== hw/rtl/prf_pkg.sv =====
// ----------------------------------------------------------------------------
// prf_pkg: shared types and constants for the page replacement unit
// Frame geometry, the search token that walks the cell row and the
// update broadcast sent back to every cell when a reference commits.
// ----------------------------------------------------------------------------
package prf_pkg;

	localparam int FRAMES  = 16;
	localparam int IDX_W   = 4;   // frame index
	localparam int RANK_W  = 4;   // recency rank
	localparam int NCNT_W  = 5;   // frame count, 0..FRAMES
	localparam int PAGE_W  = 16;
	localparam int TOTAL_W = 32;

	localparam logic [NCNT_W-1:0]  FRAMES_N   = NCNT_W'(FRAMES);
	localparam logic [NCNT_W-1:0]  FRAMES_RST = NCNT_W'(16);
	localparam logic [TOTAL_W-1:0] TOTAL_MAX  = '1;

	typedef enum logic {
		MODE_FIFO = 1'b0,
		MODE_LRU  = 1'b1
	} mode_t;

	typedef enum logic {
		REG_MODE   = 1'b0,
		REG_FRAMES = 1'b1
	} reg_idx_t;

	// search token, one per reference, moves one cell per cycle
	typedef struct packed {
		logic              vld;
		logic [PAGE_W-1:0] page;
		logic              hit;
		logic [IDX_W-1:0]  hit_idx;
		logic [RANK_W-1:0] hit_rank;
		logic              emp;
		logic [IDX_W-1:0]  emp_idx;
		logic              min_set;
		logic [IDX_W-1:0]  min_idx;
		logic [RANK_W-1:0] min_rank;
		logic [PAGE_W-1:0] min_page;
		logic [IDX_W-1:0]  fifo_idx;
		logic              fifo_valid;
		logic [PAGE_W-1:0] fifo_page;
		logic [NCNT_W-1:0] cnt;
	} tok_t;

	// commit broadcast to the cell row
	typedef struct packed {
		logic              en;
		logic              fault;
		logic              lru;
		logic [IDX_W-1:0]  target;
		logic              was;
		logic [RANK_W-1:0] old_rank;
		logic [RANK_W-1:0] others;
		logic [PAGE_W-1:0] page;
	} upd_t;

endpackage

// ===== hw/rtl/prf_cell.sv =====
// ----------------------------------------------------------------------------
// prf_cell: one frame of the page replacement row
// Holds page, valid and recency rank of one frame, folds its frame into
// the passing search token and applies the commit broadcast.
// ----------------------------------------------------------------------------
module prf_cell
	import prf_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic [IDX_W-1:0]  idx,
	input  logic [NCNT_W-1:0] n_active,
	input  logic              clr,
	input  upd_t              upd,
	input  tok_t              tok_in,
	output tok_t              tok_out
);

	logic [PAGE_W-1:0] page_q;
	logic              valid_q;
	logic [RANK_W-1:0] rank_q;
	logic              vld_q;
	tok_t              tok_q;
	tok_t              tok_d;
	logic              active;
	logic              live;

	assign active = {1'b0, idx} < n_active;
	assign live   = active && valid_q;

	always_comb begin
		tok_d = tok_in;
		if (live && page_q == tok_in.page && !tok_in.hit) begin
			tok_d.hit      = 1'b1;
			tok_d.hit_idx  = idx;
			tok_d.hit_rank = rank_q;
		end
		if (active && !valid_q && !tok_in.emp) begin
			tok_d.emp     = 1'b1;
			tok_d.emp_idx = idx;
		end
		// strict compare keeps the lowest index on equal ranks
		if (active && (!tok_in.min_set || rank_q < tok_in.min_rank)) begin
			tok_d.min_set  = 1'b1;
			tok_d.min_idx  = idx;
			tok_d.min_rank = rank_q;
			tok_d.min_page = page_q;
		end
		if (idx == tok_in.fifo_idx) begin
			tok_d.fifo_valid = valid_q;
			tok_d.fifo_page  = page_q;
		end
		tok_d.cnt = tok_in.cnt + NCNT_W'(live);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else begin
			vld_q <= tok_in.vld;
		end
	end

	always_ff @(posedge clk) begin
		tok_q <= tok_d;
	end

	always_comb begin
		tok_out     = tok_q;
		tok_out.vld = vld_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			rank_q  <= '0;
		end else if (clr) begin
			valid_q <= 1'b0;
			rank_q  <= '0;
		end else if (upd.en) begin
			if (upd.lru) begin
				if (idx == upd.target) begin
					rank_q <= upd.others;
				end else if (live && upd.was && rank_q > upd.old_rank) begin
					rank_q <= rank_q - RANK_W'(1);
				end
			end
			if (upd.fault && idx == upd.target) begin
				valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (upd.en && upd.fault && idx == upd.target) begin
			page_q <= upd.page;
		end
	end

endmodule

// ===== hw/rtl/page_replacement_fifo_lru.sv =====
// ----------------------------------------------------------------------------
// page_replacement_fifo_lru: FIFO / LRU page replacement over a frame row
// The reference is registered at launch, in each frame cell of the row,
// in the finished-token register and in the result register. The search
// token walks the row of frame cells one cell per cycle and the next word
// is taken once the previous reference has committed to the row.
// Reset: frames empty, ranks, pointer and fault count zero, FIFO mode,
// 16 frames in use; page contents are left as they are.
// ----------------------------------------------------------------------------
module page_replacement_fifo_lru
	import prf_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	// config write port
	input  logic              cfg_we,
	input  logic              cfg_index,
	input  logic [NCNT_W-1:0] cfg_data,
	// input stream
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [15:0]       s_tdata,   // [15:0] page_number
	input  logic              s_tuser,   // [0] restart
	// result stream
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [55:0]       m_tdata,   // [3:0] slot, [19:4] evicted_page,
	                                     // [51:20] fault_total, rest zero
	output logic [1:0]        m_tuser    // [0] hit, [1] evicted_valid
);

	mode_t              mode_q;
	logic [NCNT_W-1:0]  frames_q;
	logic [NCNT_W-1:0]  n_active;
	logic [IDX_W-1:0]   ptr_q;
	logic [TOTAL_W-1:0] total_q;
	logic               busy_q;
	logic               fin_vld_q;
	tok_t               fin_q;
	tok_t               tok [FRAMES+1];
	tok_t               launch_q;
	logic               launch_vld_q;
	tok_t               launch_tok;
	upd_t               upd;
	logic               accept;
	logic               commit;
	logic               restart;
	logic [IDX_W-1:0]   fifo_start;
	logic [IDX_W-1:0]   victim;
	logic [NCNT_W-1:0]  ptr_next;
	logic               ev_valid;
	logic [PAGE_W-1:0]  ev_page;
	logic [TOTAL_W-1:0] total_next;

	logic               m_tvalid_q;
	logic               hit_q;
	logic               evv_q;
	logic [IDX_W-1:0]   slot_q;
	logic [PAGE_W-1:0]  evp_q;
	logic [TOTAL_W-1:0] tot_q;

	assign s_tready = !busy_q;
	assign accept   = s_tvalid && s_tready;
	assign restart  = s_tuser;
	assign commit   = fin_vld_q && (!m_tvalid_q || m_tready);

	// out-of-range frame counts are clamped into 1..FRAMES
	always_comb begin
		priority if (frames_q == '0) begin
			n_active = NCNT_W'(1);
		end else if (frames_q > FRAMES_N) begin
			n_active = FRAMES_N;
		end else begin
			n_active = frames_q;
		end
	end

	assign fifo_start = (restart || {1'b0, ptr_q} >= n_active) ? '0 : ptr_q;

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= MODE_FIFO;
			frames_q <= FRAMES_RST;
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_index))
				REG_MODE:   mode_q   <= mode_t'(cfg_data[0]);
				REG_FRAMES: frames_q <= cfg_data;
				default:    ;
			endcase
		end
	end

	// token launch into the first cell
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			launch_vld_q <= 1'b0;
		end else begin
			launch_vld_q <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			launch_q.vld        <= 1'b1;
			launch_q.page       <= s_tdata;
			launch_q.hit        <= 1'b0;
			launch_q.hit_idx    <= '0;
			launch_q.hit_rank   <= '0;
			launch_q.emp        <= 1'b0;
			launch_q.emp_idx    <= '0;
			launch_q.min_set    <= 1'b0;
			launch_q.min_idx    <= '0;
			launch_q.min_rank   <= '0;
			launch_q.min_page   <= '0;
			launch_q.fifo_idx   <= fifo_start;
			launch_q.fifo_valid <= 1'b0;
			launch_q.fifo_page  <= '0;
			launch_q.cnt        <= '0;
		end
	end

	always_comb begin
		launch_tok     = launch_q;
		launch_tok.vld = launch_vld_q;
	end

	assign tok[0] = launch_tok;

	for (genvar g = 0; g < FRAMES; g++) begin : g_cell
		prf_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.idx      (IDX_W'(g)),
			.n_active (n_active),
			.clr      (accept && restart),
			.upd      (upd),
			.tok_in   (tok[g]),
			.tok_out  (tok[g+1])
		);
	end

	// hold the finished token until the result register is free
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q    <= 1'b0;
			fin_vld_q <= 1'b0;
		end else begin
			if (accept) begin
				busy_q <= 1'b1;
			end else if (commit) begin
				busy_q <= 1'b0;
			end
			if (tok[FRAMES].vld) begin
				fin_vld_q <= 1'b1;
			end else if (commit) begin
				fin_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (tok[FRAMES].vld) begin
			fin_q <= tok[FRAMES];
		end
	end

	// commit decision
	always_comb begin
		upd          = '0;
		upd.en       = commit;
		upd.fault    = !fin_q.hit;
		upd.lru      = (mode_q == MODE_LRU);
		upd.page     = fin_q.page;
		upd.was      = 1'b1;
		upd.others   = RANK_W'(fin_q.cnt - NCNT_W'(1));
		ev_valid     = 1'b0;
		ev_page      = '0;
		victim       = fin_q.fifo_idx;
		if (fin_q.hit) begin
			victim       = fin_q.hit_idx;
			upd.old_rank = fin_q.hit_rank;
		end else if (mode_q == MODE_LRU) begin
			if (fin_q.emp) begin
				victim     = fin_q.emp_idx;
				upd.was    = 1'b0;
				upd.others = RANK_W'(fin_q.cnt);
			end else begin
				victim       = fin_q.min_idx;
				upd.old_rank = fin_q.min_rank;
				ev_valid     = 1'b1;
				ev_page      = fin_q.min_page;
			end
		end else begin
			ev_valid = fin_q.fifo_valid;
			ev_page  = fin_q.fifo_valid ? fin_q.fifo_page : '0;
		end
		upd.target = victim;
	end

	assign ptr_next   = ({1'b0, fin_q.fifo_idx} + NCNT_W'(1) == n_active)
	                    ? '0 : {1'b0, fin_q.fifo_idx} + NCNT_W'(1);
	assign total_next = (total_q == TOTAL_MAX) ? total_q : total_q + TOTAL_W'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q   <= '0;
			total_q <= '0;
		end else if (accept && restart) begin
			ptr_q   <= '0;
			total_q <= '0;
		end else if (commit && !fin_q.hit) begin
			total_q <= total_next;
			if (mode_q == MODE_FIFO) begin
				ptr_q <= ptr_next[IDX_W-1:0];
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (commit) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			hit_q  <= fin_q.hit;
			slot_q <= victim;
			evv_q  <= ev_valid;
			evp_q  <= ev_page;
			tot_q  <= fin_q.hit ? total_q : total_next;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tuser  = {evv_q, hit_q};
	assign m_tdata  = {4'b0, tot_q, evp_q, slot_q};

	// only one reference in flight
	a_single_token: assert property (@(posedge clk) disable iff (!arst_n)
		tok[FRAMES].vld |-> !fin_vld_q && busy_q)
		else $error("second token reached the end of the row");

	a_fin_busy: assert property (@(posedge clk) disable iff (!arst_n)
		fin_vld_q |-> busy_q)
		else $error("finished token without an item in flight");

	a_evict_fault: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid_q && evv_q |-> !hit_q)
		else $error("eviction reported on a hit");

	a_fault_counts: assert property (@(posedge clk) disable iff (!arst_n)
		commit && !fin_q.hit |=> total_q != '0)
		else $error("fault did not advance the fault count");

endmodule

// ===== bench/prf_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prf_checker: scoreboard for the page replacement unit
// Watches the config port and both streams, keeps its own copy of the frame
// table, recency ranks, fifo pointer and fault count, predicts one result
// per accepted reference and compares it field by field with the result
// words in order.
// ----------------------------------------------------------------------------
module prf_checker
	import prf_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic              cfg_index,
	input  logic [NCNT_W-1:0] cfg_data,
	input  logic              s_tvalid,
	input  logic              s_tready,
	input  logic [15:0]       s_tdata,   // [15:0] page_number
	input  logic              s_tuser,   // [0] restart
	input  logic              m_tvalid,
	input  logic              m_tready,
	input  logic [55:0]       m_tdata,   // [3:0] slot, [19:4] evicted_page, [51:20] fault_total
	input  logic [1:0]        m_tuser,   // [0] hit, [1] evicted_valid
	output int                fail_count,
	output int                pending
);

	typedef struct packed {
		logic               hit;
		logic [IDX_W-1:0]   slot;
		logic               ev_vld;
		logic [PAGE_W-1:0]  ev_page;
		logic [TOTAL_W-1:0] total;
	} outcome_t;

	logic [PAGE_W-1:0]  page_of [FRAMES];
	bit                 resident [FRAMES];
	logic [RANK_W-1:0]  rank_of [FRAMES];
	logic [IDX_W-1:0]   fifo_ptr;
	logic [TOTAL_W-1:0] faults;
	mode_t              policy;
	logic [NCNT_W-1:0]  frames_cfg;
	outcome_t           outcome_q [$];
	int                 errors;

	function automatic void flush_frames();
		for (int i = 0; i < FRAMES; i++) begin
			resident[i] = 1'b0;
			rank_of[i]  = '0;
		end
		fifo_ptr = '0;
		faults   = '0;
	endfunction

	// frame f becomes the most recent of the valid active frames
	function automatic void promote(int f, int n);
		logic [RANK_W-1:0] old;
		bit                was;
		int                others;
		old    = rank_of[f];
		was    = resident[f];
		others = 0;
		for (int g = 0; g < n; g++) begin
			if (g != f && resident[g]) begin
				if (was && rank_of[g] > old)
					rank_of[g] = rank_of[g] - 1'b1;
				others++;
			end
		end
		rank_of[f] = RANK_W'(others);
	endfunction

	function automatic outcome_t replace_page(logic [PAGE_W-1:0] pg, logic rs);
		int       n;
		int       v;
		bit       found;
		bit       empty;
		outcome_t r;
		if (rs)
			flush_frames();
		n = int'(frames_cfg);
		if (n < 1) n = 1;
		if (n > FRAMES) n = FRAMES;
		r     = '0;
		found = 1'b0;
		v     = 0;
		for (int i = 0; i < n; i++) begin
			if (!found && resident[i] && page_of[i] == pg) begin
				v     = i;
				found = 1'b1;
			end
		end
		if (found) begin
			if (policy == MODE_LRU)
				promote(v, n);
			r.hit   = 1'b1;
			r.slot  = IDX_W'(v);
			r.total = faults;
			return r;
		end
		if (policy == MODE_LRU) begin
			empty = 1'b0;
			for (int i = 0; i < n; i++) begin
				if (!empty && !resident[i]) begin
					v     = i;
					empty = 1'b1;
				end
			end
			if (!empty) begin
				v = 0;
				for (int i = 1; i < n; i++)
					if (rank_of[i] < rank_of[v]) v = i;
			end
		end else begin
			// stale pointer past the active set counts as frame 0
			v        = (int'(fifo_ptr) < n) ? int'(fifo_ptr) : 0;
			fifo_ptr = IDX_W'((v + 1) % n);
		end
		r.ev_vld = resident[v];
		if (resident[v])
			r.ev_page = page_of[v];
		if (policy == MODE_LRU)
			promote(v, n);
		page_of[v]  = pg;
		resident[v] = 1'b1;
		if (faults != TOTAL_MAX)
			faults = faults + 1'b1;
		r.slot  = IDX_W'(v);
		r.total = faults;
		return r;
	endfunction

	task automatic check_field(input string name, input longint unsigned want,
		input longint unsigned got);
		if (want != got) begin
			$display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
			errors++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		outcome_t want;
		if (!arst_n) begin
			flush_frames();
			policy     = MODE_FIFO;
			frames_cfg = FRAMES_RST;
			outcome_q.delete();
			errors     = 0;
			fail_count <= 0;
			pending    <= 0;
		end else begin
			if (cfg_we) begin
				if (reg_idx_t'(cfg_index) == REG_MODE)
					policy = mode_t'(cfg_data[0]);
				else
					frames_cfg = cfg_data;
			end
			if (s_tvalid && s_tready)
				outcome_q.push_back(replace_page(s_tdata, s_tuser));
			if (m_tvalid && m_tready) begin
				if (outcome_q.size() == 0) begin
					$display("%0t: result word with nothing expected, actual %0h/%0h",
						$time, m_tuser, m_tdata);
					errors++;
				end else begin
					want = outcome_q.pop_front();
					check_field("hit", want.hit, m_tuser[0]);
					check_field("evicted_valid", want.ev_vld, m_tuser[1]);
					check_field("slot", want.slot, m_tdata[3:0]);
					check_field("evicted_page", want.ev_page, m_tdata[19:4]);
					check_field("fault_total", want.total, m_tdata[51:20]);
				end
			end
			fail_count <= errors;
			pending    <= outcome_q.size();
		end
	end

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: testbench for page_replacement_fifo_lru
// Drives page references through directed corner cases and then random
// phases of policy and frame count, with random stalls on both streams;
// the checker predicts and compares, this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_top;
	import prf_pkg::*;

	logic              clk;
	logic              arst_n;
	logic              cfg_we;
	logic              cfg_index;
	logic [NCNT_W-1:0] cfg_data;
	logic              s_tvalid;
	logic              s_tready;
	logic [15:0]       s_tdata;   // [15:0] page_number
	logic              s_tuser;   // [0] restart
	logic              m_tvalid;
	logic              m_tready;
	logic [55:0]       m_tdata;   // [3:0] slot, [19:4] evicted_page, [51:20] fault_total
	logic [1:0]        m_tuser;   // [0] hit, [1] evicted_valid
	int                fail_count;
	int                pending;
	bit                quiet;
	int                sent;

	page_replacement_fifo_lru uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	prf_checker chk (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.fail_count(fail_count),
		.pending   (pending)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#5ms;
		$display("FAIL");
		$finish;
	end

	// result side back-pressure
	initial begin
		int n;
		m_tready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (!quiet && $urandom_range(0, 5) == 0) begin
				n = $urandom_range(1, 10);
				m_tready <= 1'b0;
				repeat (n) @(posedge clk);
			end
			m_tready <= 1'b1;
		end
	end

	task automatic send_ref(input logic [15:0] pg, input logic rs);
		int gap;
		if (!quiet && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 10);
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= pg;
		s_tuser  <= rs;
		do @(posedge clk); while (!s_tready);
		sent++;
	endtask

	// hold the sender until every result is back and the row is quiet
	task automatic wait_settled();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (FRAMES + 6) @(posedge clk);
	endtask

	task automatic apply_setting(input mode_t md, input logic [NCNT_W-1:0] nf);
		wait_settled();
		cfg_we    <= 1'b1;
		cfg_index <= REG_MODE;
		cfg_data  <= NCNT_W'(md);
		@(posedge clk);
		cfg_index <= REG_FRAMES;
		cfg_data  <= nf;
		@(posedge clk);
		cfg_we    <= 1'b0;
		@(posedge clk);
	endtask

	task automatic run_phase(input mode_t md, input logic [NCNT_W-1:0] nf,
		input int count, input bit restart_first);
		int          eff;
		int          span;
		logic [15:0] base;
		logic [15:0] pg;
		logic        rs;
		apply_setting(md, nf);
		eff = int'(nf);
		if (eff < 1) eff = 1;
		if (eff > FRAMES) eff = FRAMES;
		// pool a bit larger than the active set gives both hits and evictions
		span = eff + eff / 2 + 1;
		base = 16'($urandom);
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(0, 9) == 0)
				pg = 16'($urandom);
			else
				pg = base + 16'($urandom_range(0, span));
			rs = (i == 0 && restart_first) || ($urandom_range(0, 39) == 0);
			send_ref(pg, rs);
		end
	endtask

	initial begin
		mode_t             md;
		logic [NCNT_W-1:0] nf;
		int                pick;
		arst_n    <= 1'b0;
		cfg_we    <= 1'b0;
		cfg_index <= REG_MODE;
		cfg_data  <= '0;
		s_tvalid  <= 1'b0;
		s_tdata   <= '0;
		s_tuser   <= 1'b0;
		quiet     = 1'b0;
		sent      = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset setting: fifo over 16 frames, page extremes and a restart
		send_ref(16'h0000, 1'b0);
		send_ref(16'hFFFF, 1'b0);
		send_ref(16'h0000, 1'b0);
		send_ref(16'hFFFF, 1'b1);
		send_ref(16'h0007, 1'b0);
		send_ref(16'h0008, 1'b0);
		// shrink without restart: stale pointer, page left in two frames
		apply_setting(MODE_FIFO, 5'd1);
		send_ref(16'h0008, 1'b0);
		apply_setting(MODE_FIFO, 5'd16);
		send_ref(16'h0008, 1'b0);
		send_ref(16'h0009, 1'b0);
		// lru over two frames
		apply_setting(MODE_LRU, 5'd2);
		send_ref(16'hA5A5, 1'b1);
		send_ref(16'h5A5A, 1'b0);
		send_ref(16'hA5A5, 1'b0);
		send_ref(16'h1111, 1'b0);
		send_ref(16'h5A5A, 1'b0);
		// frame count of zero acts as one
		apply_setting(MODE_LRU, 5'd0);
		send_ref(16'h1234, 1'b0);
		send_ref(16'h1234, 1'b0);
		// frame count above the row acts as the full row
		apply_setting(MODE_FIFO, 5'd31);
		send_ref(16'h4321, 1'b1);
		send_ref(16'h8000, 1'b0);
		send_ref(16'h7FFF, 1'b0);

		sent = 0;
		while (sent < 850) begin
			md   = mode_t'($urandom_range(0, 1));
			pick = $urandom_range(0, 99);
			if (pick < 40)
				nf = NCNT_W'($urandom_range(1, 4));
			else if (pick < 70)
				nf = NCNT_W'($urandom_range(5, 16));
			else if (pick < 85)
				nf = FRAMES_N;
			else if (pick < 90)
				nf = '0;
			else
				nf = NCNT_W'($urandom_range(17, 31));
			run_phase(md, nf, $urandom_range(20, 60), $urandom_range(0, 9) < 7);
		end

		// closing stretch at full rate on both sides
		quiet = 1'b1;
		run_phase(MODE_LRU, FRAMES_N, 60, 1'b1);

		wait_settled();
		repeat (FRAMES + 8) @(posedge clk);
		if (fail_count == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule

// ===== files.f =====
hw/rtl/prf_pkg.sv
hw/rtl/prf_cell.sv
hw/rtl/page_replacement_fifo_lru.sv
bench/prf_checker.sv
bench/tb_top.sv
